/* rtl/damxb_pkg.sv */
// ============================================================================
// damxb_pkg
// Shared types, constants and helpers of the xor-bank DRAM address map.
// ============================================================================
package damxb_pkg;

    localparam int FIELD_BITS      = 40;
    localparam int BANK_BITS       = 5;
    localparam int HASH_SLOTS      = 5;
    localparam int ADDR_BITS       = 40;
    localparam int MAX_BANK_HASHES = 5;
    localparam int COUNT_BITS      = 3;
    localparam int SHIFT_BITS      = $clog2(FIELD_BITS);
    localparam int REG_COUNT       = 8;
    localparam int DATA_BITS       = 64;
    localparam int PADDR_BITS      = $clog2(REG_COUNT * 8);

    localparam int WRAP_BITS = (ADDR_BITS < FIELD_BITS) ? ADDR_BITS : FIELD_BITS;
    localparam int USE_LIMIT = (MAX_BANK_HASHES < HASH_SLOTS) ? MAX_BANK_HASHES : HASH_SLOTS;
    localparam logic [FIELD_BITS-1:0] ADDR_MASK =
        {FIELD_BITS{1'b1}} >> (FIELD_BITS - WRAP_BITS);

    typedef enum logic [2:0] {
        REG_ROW_BITS    = 3'd0,
        REG_COL_MASK    = 3'd1,
        REG_HASH_COUNT  = 3'd2,
        REG_HASH_MASK_0 = 3'd3,
        REG_HASH_MASK_1 = 3'd4,
        REG_HASH_MASK_2 = 3'd5,
        REG_HASH_MASK_3 = 3'd6,
        REG_HASH_MASK_4 = 3'd7
    } reg_idx_t;

    typedef enum logic {
        CMD_TO_DRAM = 1'b0,
        CMD_TO_PHYS = 1'b1
    } cmd_t;

    typedef struct packed {
        logic [FIELD_BITS-1:0]                  row_bits;
        logic [FIELD_BITS-1:0]                  col_mask;
        logic [SHIFT_BITS-1:0]                  row_shift;
        logic [SHIFT_BITS-1:0]                  col_shift;
        logic [HASH_SLOTS-1:0]                  used;
        logic [HASH_SLOTS-1:0][FIELD_BITS-1:0]  hash_mask;
        logic [HASH_SLOTS-1:0][FIELD_BITS-1:0]  flip;
        logic [HASH_SLOTS-1:0][HASH_SLOTS-1:0]  hit;
    } cfg_t;

    typedef struct packed {
        cmd_t                  cmd;
        logic [FIELD_BITS-1:0] phys;
        logic [BANK_BITS-1:0]  bank;
        logic [FIELD_BITS-1:0] row;
        logic [FIELD_BITS-1:0] col;
    } req_t;

    typedef struct packed {
        cmd_t                  cmd;
        logic [FIELD_BITS-1:0] addr;
        logic [BANK_BITS-1:0]  want;
        logic [FIELD_BITS-1:0] row_out;
        logic [FIELD_BITS-1:0] col_out;
    } addr_t;

    typedef struct packed {
        cmd_t                  cmd;
        logic [FIELD_BITS-1:0] addr;
        logic [BANK_BITS-1:0]  want;
        logic [FIELD_BITS-1:0] row_out;
        logic [FIELD_BITS-1:0] col_out;
        logic [HASH_SLOTS-1:0] par;
    } par_t;

    typedef struct packed {
        logic [FIELD_BITS-1:0] phys;
        logic [BANK_BITS-1:0]  bank;
        logic [FIELD_BITS-1:0] row;
        logic [FIELD_BITS-1:0] col;
    } rsp_t;

    // index of the lowest set bit, zero for an empty mask
    function automatic logic [SHIFT_BITS-1:0] low_bit_index(input logic [FIELD_BITS-1:0] v);
        logic [SHIFT_BITS-1:0] idx;
        idx = '0;
        for (int i = FIELD_BITS - 1; i >= 0; i--)
        begin
            if (v[i])
            begin
                idx = SHIFT_BITS'(i);
            end
        end
        return idx;
    endfunction

    // one-hot of the lowest set bit, zero for an empty mask
    function automatic logic [FIELD_BITS-1:0] lowest_bit(input logic [FIELD_BITS-1:0] v);
        return v & (~v + FIELD_BITS'(1));
    endfunction

endpackage

/* rtl/dram_address_map_xor_bank.sv */
// ============================================================================
// dram_address_map_xor_bank
// Physical address to DRAM bank, row and column and back, with xor bank hashes.
// ============================================================================
//
//  channel   handshake                        payload
//  request   in_valid / in_ready              command, phys_in, bank_in, row_in, column_in
//  result    out_valid / out_ready            phys_out, bank_out, row_out, column_out
//  config    psel, penable, pwrite, pready    paddr, pwdata, prdata
//
//  one request per clock while out_ready does not stall the pipeline; a result passes through every stage register
//  stages: request register, row and column shift, hash parity, fixup and output register
//  derived mask values are registered again from the config registers after a config write
//  reset clears the config registers and the stage valid flags and empties the pipeline
//  a stalled result holds every stage that cannot move; no request is lost or repeated
//
module dram_address_map_xor_bank
    import damxb_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic                  command,
    input  logic [FIELD_BITS-1:0] phys_in,
    input  logic [BANK_BITS-1:0]  bank_in,
    input  logic [FIELD_BITS-1:0] row_in,
    input  logic [FIELD_BITS-1:0] column_in,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [FIELD_BITS-1:0] phys_out,
    output logic [BANK_BITS-1:0]  bank_out,
    output logic [FIELD_BITS-1:0] row_out,
    output logic [FIELD_BITS-1:0] column_out,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [PADDR_BITS-1:0] paddr,
    input  logic [DATA_BITS-1:0]  pwdata,
    output logic [DATA_BITS-1:0]  prdata,
    output logic                  pready
);

    cfg_t  cfg;
    req_t  req;
    addr_t addr;
    logic  addr_valid;
    logic  addr_ready;
    par_t  par;
    logic  par_valid;
    logic  par_ready;
    rsp_t  rsp;

    assign req.cmd  = cmd_t'(command);
    assign req.phys = phys_in;
    assign req.bank = bank_in;
    assign req.row  = row_in;
    assign req.col  = column_in;

    damxb_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    damxb_shift u_shift (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .req       (req),
        .out_valid (addr_valid),
        .out_ready (addr_ready),
        .out       (addr)
    );

    damxb_parity u_parity (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (addr_valid),
        .in_ready  (addr_ready),
        .in        (addr),
        .out_valid (par_valid),
        .out_ready (par_ready),
        .out       (par)
    );

    damxb_resolve u_resolve (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (par_valid),
        .in_ready  (par_ready),
        .in        (par),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out       (rsp)
    );

    assign phys_out   = rsp.phys;
    assign bank_out   = rsp.bank;
    assign row_out    = rsp.row;
    assign column_out = rsp.col;

endmodule

/* rtl/damxb_cfg.sv */
// ============================================================================
// damxb_cfg
// Register file on the APB-style port and the mask values derived from it.
// ============================================================================
module damxb_cfg
    import damxb_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [PADDR_BITS-1:0] paddr,
    input  logic [DATA_BITS-1:0]  pwdata,
    output logic [DATA_BITS-1:0]  prdata,
    output logic                  pready,
    output cfg_t                  cfg
);

    logic [FIELD_BITS-1:0]                 row_bits_reg, row_bits_next;
    logic [FIELD_BITS-1:0]                 col_mask_reg, col_mask_next;
    logic [COUNT_BITS-1:0]                 count_reg, count_next;
    logic [HASH_SLOTS-1:0][FIELD_BITS-1:0] hash_mask_reg, hash_mask_next;
    cfg_t                                  cfg_reg, cfg_next;
    logic                                  wr;
    reg_idx_t                              idx;
    logic [COUNT_BITS-1:0]                 count_sat;
    logic [HASH_SLOTS-1:0][FIELD_BITS-1:0] free_bits;

    assign wr     = psel & penable & pwrite;
    assign idx    = reg_idx_t'(paddr[PADDR_BITS-1:3]);
    assign pready = 1'b1;

    always_comb
    begin
        row_bits_next  = row_bits_reg;
        col_mask_next  = col_mask_reg;
        count_next     = count_reg;
        hash_mask_next = hash_mask_reg;
        if (wr)
        begin
            case (idx)
                REG_ROW_BITS:    row_bits_next     = pwdata[FIELD_BITS-1:0];
                REG_COL_MASK:    col_mask_next     = pwdata[FIELD_BITS-1:0];
                REG_HASH_COUNT:  count_next        = pwdata[COUNT_BITS-1:0];
                REG_HASH_MASK_0: hash_mask_next[0] = pwdata[FIELD_BITS-1:0];
                REG_HASH_MASK_1: hash_mask_next[1] = pwdata[FIELD_BITS-1:0];
                REG_HASH_MASK_2: hash_mask_next[2] = pwdata[FIELD_BITS-1:0];
                REG_HASH_MASK_3: hash_mask_next[3] = pwdata[FIELD_BITS-1:0];
                REG_HASH_MASK_4: hash_mask_next[4] = pwdata[FIELD_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            REG_ROW_BITS:    prdata = DATA_BITS'(row_bits_reg);
            REG_COL_MASK:    prdata = DATA_BITS'(col_mask_reg);
            REG_HASH_COUNT:  prdata = DATA_BITS'(count_reg);
            REG_HASH_MASK_0: prdata = DATA_BITS'(hash_mask_reg[0]);
            REG_HASH_MASK_1: prdata = DATA_BITS'(hash_mask_reg[1]);
            REG_HASH_MASK_2: prdata = DATA_BITS'(hash_mask_reg[2]);
            REG_HASH_MASK_3: prdata = DATA_BITS'(hash_mask_reg[3]);
            REG_HASH_MASK_4: prdata = DATA_BITS'(hash_mask_reg[4]);
            default:         prdata = '0;
        endcase
    end

    // derived values, registered from the written config registers
    assign count_sat = (count_reg > COUNT_BITS'(USE_LIMIT)) ? COUNT_BITS'(USE_LIMIT) : count_reg;

    always_comb
    begin
        cfg_next           = '0;
        cfg_next.row_bits  = row_bits_reg;
        cfg_next.col_mask  = col_mask_reg;
        cfg_next.row_shift = low_bit_index(row_bits_reg);
        cfg_next.col_shift = low_bit_index(col_mask_reg);
        cfg_next.hash_mask = hash_mask_reg;
        for (int k = 0; k < HASH_SLOTS; k++)
        begin
            cfg_next.used[k] = (k < int'(count_sat));
            free_bits[k]     = hash_mask_reg[k] & ~row_bits_reg & ~col_mask_reg;
            cfg_next.flip[k] = lowest_bit(free_bits[k]);
        end
        for (int k = 0; k < HASH_SLOTS; k++)
        begin
            for (int j = 0; j < HASH_SLOTS; j++)
            begin
                cfg_next.hit[k][j] = |(cfg_next.flip[k] & hash_mask_reg[j]);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_bits_reg  <= '0;
            col_mask_reg  <= '0;
            count_reg     <= '0;
            hash_mask_reg <= '0;
            cfg_reg       <= '0;
        end
        else
        begin
            row_bits_reg  <= row_bits_next;
            col_mask_reg  <= col_mask_next;
            count_reg     <= count_next;
            hash_mask_reg <= hash_mask_next;
            cfg_reg       <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

    // hashes in use form a prefix and follow the saturated count
    a_used_prefix: assert property (@(posedge clk) disable iff (!rst_n)
        (cfg_reg.used & (cfg_reg.used + 1'b1)) == '0)
        else $error("hash enables not a prefix");

    a_used_count: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> $countones(cfg_reg.used) == int'($past(count_sat)))
        else $error("hash enables disagree with count");

    generate
        for (genvar g = 0; g < HASH_SLOTS; g++)
        begin : g_flip_chk
            a_flip_free: assert property (@(posedge clk) disable iff (!rst_n)
                1'b1 |=> $onehot0(cfg_reg.flip[g]) &&
                    ((cfg_reg.flip[g] & $past(row_bits_reg | col_mask_reg)) == '0))
                else $error("flip bit not a single free bit");
        end
    endgenerate

endmodule

/* rtl/damxb_shift.sv */
// ============================================================================
// damxb_shift
// Request register and the stage that shifts row and column into place.
// ============================================================================
module damxb_shift
    import damxb_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  cfg_t  cfg,
    input  logic  in_valid,
    output logic  in_ready,
    input  req_t  req,
    output logic  out_valid,
    input  logic  out_ready,
    output addr_t out
);

    logic  req_v_reg;
    req_t  req_reg, req_next;
    logic  addr_v_reg;
    addr_t addr_reg, addr_next;
    logic  addr_ready;

    assign addr_ready = !addr_v_reg || out_ready;
    assign in_ready   = !req_v_reg || addr_ready;
    assign req_next   = req;

    always_comb
    begin
        addr_next      = '0;
        addr_next.cmd  = req_reg.cmd;
        addr_next.want = req_reg.bank;
        if (req_reg.cmd == CMD_TO_DRAM)
        begin
            addr_next.addr    = req_reg.phys;
            addr_next.row_out = (req_reg.phys >> cfg.row_shift) & ADDR_MASK;
            addr_next.col_out = req_reg.phys & cfg.col_mask & ADDR_MASK;
        end
        else
        begin
            addr_next.addr = (req_reg.row << cfg.row_shift) | (req_reg.col << cfg.col_shift);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_v_reg  <= 1'b0;
            addr_v_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                req_v_reg <= in_valid;
            end
            if (addr_ready)
            begin
                addr_v_reg <= req_v_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            req_reg <= req_next;
        end
        if (addr_ready && req_v_reg)
        begin
            addr_reg <= addr_next;
        end
    end

    assign out_valid = addr_v_reg;
    assign out       = addr_reg;

endmodule

/* rtl/damxb_parity.sv */
// ============================================================================
// damxb_parity
// Parity of the working address under each bank hash mask.
// ============================================================================
module damxb_parity
    import damxb_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  cfg_t  cfg,
    input  logic  in_valid,
    output logic  in_ready,
    input  addr_t in,
    output logic  out_valid,
    input  logic  out_ready,
    output par_t  out
);

    logic par_v_reg;
    par_t par_reg, par_next;

    assign in_ready = !par_v_reg || out_ready;

    always_comb
    begin
        par_next.cmd     = in.cmd;
        par_next.addr    = in.addr;
        par_next.want    = in.want;
        par_next.row_out = in.row_out;
        par_next.col_out = in.col_out;
        for (int k = 0; k < HASH_SLOTS; k++)
        begin
            par_next.par[k] = ^(in.addr & cfg.hash_mask[k]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            par_v_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            par_v_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            par_reg <= par_next;
        end
    end

    assign out_valid = par_v_reg;
    assign out       = par_reg;

endmodule

/* rtl/damxb_resolve.sv */
// ============================================================================
// damxb_resolve
// Bank bits, in-order hash fixups and the output register.
// ============================================================================
module damxb_resolve
    import damxb_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  cfg_t cfg,
    input  logic in_valid,
    output logic in_ready,
    input  par_t in,
    output logic out_valid,
    input  logic out_ready,
    output rsp_t out
);

    logic                  out_v_reg;
    rsp_t                  out_reg, out_next;
    logic [HASH_SLOTS-1:0] corr;
    logic [HASH_SLOTS-1:0] fix;
    logic [FIELD_BITS-1:0] flips;

    assign in_ready = !out_v_reg || out_ready;

    // each flip toggles the parity of every later hash that covers that bit
    always_comb
    begin
        corr  = '0;
        fix   = '0;
        flips = '0;
        for (int i = 0; i < HASH_SLOTS; i++)
        begin
            fix[i] = cfg.used[i] && (in.par[i] ^ in.want[i] ^ corr[i]) && (|cfg.flip[i]);
            if (fix[i])
            begin
                corr  = corr ^ cfg.hit[i];
                flips = flips ^ cfg.flip[i];
            end
        end
    end

    always_comb
    begin
        out_next = '0;
        if (in.cmd == CMD_TO_DRAM)
        begin
            out_next.bank = BANK_BITS'(in.par & cfg.used);
            out_next.row  = in.row_out;
            out_next.col  = in.col_out;
        end
        else
        begin
            out_next.phys = (in.addr ^ flips) & ADDR_MASK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            out_v_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            out_reg <= out_next;
        end
    end

    assign out_valid = out_v_reg;
    assign out       = out_reg;

endmodule
